/* hdl/i2cmte_pkg.sv */
// Shared constants for the I2C master transfer engine: bus phases, status codes, stream layout.
`default_nettype none
package i2cmte_pkg;

    // stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // bus phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START     = 4'd1;
    localparam logic [3:0] PH_TX_LOW    = 4'd2;
    localparam logic [3:0] PH_TX_HIGH   = 4'd3;
    localparam logic [3:0] PH_ACK_LOW   = 4'd4;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd5;
    localparam logic [3:0] PH_FETCH     = 4'd6;
    localparam logic [3:0] PH_RX_LOW    = 4'd7;
    localparam logic [3:0] PH_RX_HIGH   = 4'd8;
    localparam logic [3:0] PH_RACK_LOW  = 4'd9;
    localparam logic [3:0] PH_RACK_HIGH = 4'd10;
    localparam logic [3:0] PH_STOP      = 4'd11;
    localparam logic [3:0] PH_STOP_SDA  = 4'd12;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;

    // completion status
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_WR_HDR_NAK = 3'd1;
    localparam logic [2:0] STS_WR_DAT_NAK = 3'd2;
    localparam logic [2:0] STS_RD_HDR_NAK = 3'd3;
    localparam logic [2:0] STS_UNKNOWN    = 3'd4;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd400;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

endpackage
`default_nettype wire

/* hdl/i2c_master_transfer_engine.sv */
// Top level of the I2C master transfer engine: tick-driven open-drain bus sequencer.
// A tick transaction is taken into the input register, then its result is shown on m_axis.
// Throughput: one tick transaction per cycle, set by the single registered step between the
// input register and the result register; back-pressure on m_axis stalls both stages.
// Reset (i_rst_n low, synchronous): bus lines released, phase idle, all counters zero,
// half period back to 400 ticks, both pipeline registers empty.
`default_nettype none
module i2c_master_transfer_engine #(
    parameter int COUNT_BITS       = 8,
    parameter int HALF_PERIOD_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration: half_period_ticks
    input  wire logic                               i_cfg_we,
    input  wire logic [15:0]                        i_cfg_wdata,
    // tick stream in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [0] sda_in, [1] cmd_valid, [3:2] cmd_code, [11:4] header, [19:12] byte_count,
    // [20] tx_valid, [28:21] tx_data, [31:29] zero
    input  wire logic [i2cmte_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // result stream out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] tx_taken, [3] rx_valid, [11:4] rx_data,
    // [12] busy_res, [13] done_res, [16:14] status, [23:17] zero
    output logic [i2cmte_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import i2cmte_pkg::*;

    localparam int HPB = HALF_PERIOD_BITS;
    localparam int CB  = COUNT_BITS;

    // ---------------- pipeline control ----------------
    logic r_in_valid, n_in_valid;
    logic [28:0] r_in;
    logic r_out_valid;
    logic [16:0] r_out;
    logic advance;   // result stage can take a new step
    logic step;      // one tick is processed this cycle

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out};

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
    end

    // ---------------- configuration ----------------
    logic [15:0] r_half_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_cfg <= HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_cfg <= i_cfg_wdata;
        end
    end

    // register taken modulo 2^HPB; zero acts as one
    logic [47:0]    half_wide;
    logic [HPB-1:0] half_raw, half;
    assign half_wide = {32'b0, r_half_cfg};
    assign half_raw  = half_wide[HPB-1:0];
    assign half      = (half_raw == '0) ? HPB'(1) : half_raw;

    // ---------------- unpack registered tick ----------------
    logic       f_sda, f_cmd_valid, f_tx_valid;
    logic [1:0] f_code;
    logic [7:0] f_header, f_count, f_tx_data;
    logic [39:0]   count_wide;
    logic [CB-1:0] count_in;

    assign f_sda       = r_in[0];
    assign f_cmd_valid = r_in[1];
    assign f_code      = r_in[3:2];
    assign f_header    = r_in[11:4];
    assign f_count     = r_in[19:12];
    assign f_tx_valid  = r_in[20];
    assign f_tx_data   = r_in[28:21];
    assign count_wide  = {32'b0, f_count};
    assign count_in    = count_wide[CB-1:0];

    // ---------------- sequencer state ----------------
    logic [3:0]     r_phase, n_phase;
    logic [HPB-1:0] r_tick, n_tick;
    logic [3:0]     r_bit, n_bit;
    logic [7:0]     r_shift, n_shift;
    logic [CB-1:0]  r_left, n_left;
    logic           r_is_read, n_is_read;
    logic           r_in_header, n_in_header;
    logic [2:0]     r_final, n_final;
    logic           r_scl, n_scl;
    logic           r_sda, n_sda;

    logic           taken, rxv, done;
    logic [7:0]     rxd;
    logic [2:0]     sts;
    logic           do_fetch, do_rx;
    logic [HPB-1:0] tick_inc;
    logic [3:0]     bit_inc;
    logic [7:0]     shift_l;
    logic [CB-1:0]  left_dec;

    assign tick_inc = r_tick + HPB'(1);
    assign bit_inc  = r_bit + 4'd1;
    assign shift_l  = {r_shift[6:0], 1'b0};
    assign left_dec = r_left - CB'(1);

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_left      = r_left;
        n_is_read   = r_is_read;
        n_in_header = r_in_header;
        n_final     = r_final;
        n_scl       = r_scl;
        n_sda       = r_sda;
        taken       = 1'b0;
        rxv         = 1'b0;
        done        = 1'b0;
        rxd         = 8'd0;
        sts         = STS_OK;
        do_fetch    = 1'b0;
        do_rx       = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (f_cmd_valid) begin
                    if (f_code != CMD_WRITE && f_code != CMD_READ) begin
                        // unknown code: report and stay idle, bus untouched
                        n_final = STS_UNKNOWN;
                        done    = 1'b1;
                        sts     = STS_UNKNOWN;
                    end else begin
                        n_is_read   = (f_code == CMD_READ);
                        n_in_header = 1'b1;
                        n_final     = STS_OK;
                        n_shift     = f_header;
                        n_left      = count_in;
                        n_bit       = 4'd0;
                        n_sda       = 1'b1;   // start: SDA falls while SCL high
                        n_scl       = 1'b0;
                        n_phase     = PH_START;
                        n_tick      = '0;
                    end
                end
            end
            PH_FETCH: begin
                do_fetch = 1'b1;
            end
            default: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    n_tick = '0;
                    case (r_phase)
                        PH_START: begin
                            n_scl   = 1'b1;
                            n_sda   = !r_shift[7];
                            n_bit   = 4'd0;
                            n_phase = PH_TX_LOW;
                        end
                        PH_TX_LOW: begin
                            n_scl   = 1'b0;
                            n_phase = PH_TX_HIGH;
                        end
                        PH_TX_HIGH: begin
                            n_scl   = 1'b1;
                            n_shift = shift_l;
                            n_bit   = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_sda   = 1'b0;   // release for slave ACK
                                n_phase = PH_ACK_LOW;
                            end else begin
                                n_sda   = !shift_l[7];
                                n_phase = PH_TX_LOW;
                            end
                        end
                        PH_ACK_LOW: begin
                            n_scl = 1'b0;
                            if (f_sda) begin
                                if (!r_in_header) begin
                                    n_final = STS_WR_DAT_NAK;
                                end else if (r_is_read) begin
                                    n_final = STS_RD_HDR_NAK;
                                end else begin
                                    n_final = STS_WR_HDR_NAK;
                                end
                            end
                            n_phase = PH_ACK_HIGH;
                        end
                        PH_ACK_HIGH: begin
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                            if (r_final != STS_OK) begin
                                n_phase = PH_STOP;
                            end else if (r_in_header) begin
                                n_in_header = 1'b0;
                                if (r_left == '0) begin
                                    n_phase = PH_STOP;
                                end else if (r_is_read) begin
                                    do_rx = 1'b1;
                                end else begin
                                    do_fetch = 1'b1;
                                end
                            end else begin
                                n_left = left_dec;
                                if (left_dec == '0) begin
                                    n_phase = PH_STOP;
                                end else begin
                                    do_fetch = 1'b1;
                                end
                            end
                        end
                        PH_RX_LOW: begin
                            n_scl   = 1'b0;
                            n_shift = {r_shift[6:0], f_sda};
                            n_phase = PH_RX_HIGH;
                        end
                        PH_RX_HIGH: begin
                            n_scl = 1'b1;
                            n_bit = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                rxv     = 1'b1;
                                rxd     = r_shift;
                                n_sda   = (r_left != CB'(1));   // ACK all but last
                                n_phase = PH_RACK_LOW;
                            end else begin
                                n_phase = PH_RX_LOW;
                            end
                        end
                        PH_RACK_LOW: begin
                            n_scl   = 1'b0;
                            n_phase = PH_RACK_HIGH;
                        end
                        PH_RACK_HIGH: begin
                            n_scl  = 1'b1;
                            n_sda  = 1'b1;
                            n_left = left_dec;
                            if (left_dec == '0) begin
                                n_phase = PH_STOP;
                            end else begin
                                do_rx = 1'b1;
                            end
                        end
                        PH_STOP: begin
                            n_scl   = 1'b0;
                            n_phase = PH_STOP_SDA;
                        end
                        PH_STOP_SDA: begin
                            n_sda   = 1'b0;
                            done    = 1'b1;
                            sts     = r_final;
                            n_phase = PH_IDLE;
                        end
                        default: begin
                            n_scl   = 1'b0;
                            n_sda   = 1'b0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // write byte fetch: SCL and SDA held low until a byte is offered
        if (do_fetch) begin
            n_tick = '0;
            if (f_tx_valid) begin
                taken   = 1'b1;
                n_shift = f_tx_data;
                n_sda   = !f_tx_data[7];
                n_bit   = 4'd0;
                n_phase = PH_TX_LOW;
            end else begin
                n_phase = PH_FETCH;
            end
        end

        // next read byte: release SDA and clear the shifter
        if (do_rx) begin
            n_sda   = 1'b0;
            n_shift = 8'd0;
            n_bit   = 4'd0;
            n_tick  = '0;
            n_phase = PH_RX_LOW;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_left      <= '0;
            r_is_read   <= 1'b0;
            r_in_header <= 1'b0;
            r_final     <= STS_OK;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_left      <= n_left;
                r_is_read   <= n_is_read;
                r_in_header <= n_in_header;
                r_final     <= n_final;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[28:0];
        end
        if (step) begin
            r_out <= {sts, done, (n_phase != PH_IDLE), rxd, rxv, taken, n_sda, n_scl};
        end
    end

endmodule
`default_nettype wire
